@@ rtl/mcfd_pkg.sv @@
// ----------------------------------------------------------------------------
// mcfd_pkg
// Shared types, field widths and codes of the multichannel FIR decimator.
// ----------------------------------------------------------------------------
package mcfd_pkg;

    // default sizes handed to the top level
    localparam int CHANNELS_DEF   = 8;
    localparam int TAPS_DEF       = 128;

    // field widths
    localparam int CH_W           = 3;
    localparam int SAMPLE_W       = 16;
    localparam int CIDX_W         = 7;
    localparam int COEF_W         = 18;
    localparam int RATIO_W        = 9;
    localparam int TAPSREG_W      = 8;
    localparam int CFG_DATA_W     = 9;
    localparam int CFG_IDX_W      = 1;
    localparam int PHASE_W        = 8;

    // stream widths, tdata in whole bytes
    localparam int S_TDATA_W      = 48;
    localparam int S_TUSER_W      = 1;
    localparam int M_TDATA_W      = 24;

    // lowest bit of each field inside the slave tdata
    localparam int TD_CH_LSB      = 0;
    localparam int TD_SMP_LSB     = TD_CH_LSB + CH_W;
    localparam int TD_CIDX_LSB    = TD_SMP_LSB + SAMPLE_W;
    localparam int TD_CVAL_LSB    = TD_CIDX_LSB + CIDX_W;

    // arithmetic
    localparam int PROD_W         = SAMPLE_W + COEF_W;
    localparam int ACC_W          = 48;
    localparam int ROUND_SHIFT    = 17;
    localparam int ROUND_HALF     = 1 << (ROUND_SHIFT - 1);
    localparam int SMP_MAX        = 32767;
    localparam int SMP_MIN        = -32768;
    localparam int RATIO_MAX      = 256;
    localparam int COEF_MAX_DEPTH = 1 << CIDX_W;
    localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(131071);

    // command queue between front and back
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [0:0] {
        MODE_SAMPLE = 1'b0,
        MODE_COEF   = 1'b1
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RATIO = 1'b0,
        REG_TAPS  = 1'b1
    } t_reg;

    typedef enum logic [1:0] {
        CMD_COEF,
        CMD_BYPASS,
        CMD_SAMPLE
    } t_kind;

    typedef struct packed {
        t_kind                       kind;
        logic [CH_W-1:0]             ch;
        logic signed [SAMPLE_W-1:0]  sample;
        logic [CIDX_W-1:0]           cidx;
        logic signed [COEF_W-1:0]    cval;
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic pop;
        logic out_load;
        logic idle;
    } t_back_stat;

endpackage

@@ rtl/multichannel_fir_decimator.sv @@
// ----------------------------------------------------------------------------
// multichannel_fir_decimator
// Per-channel FIR low-pass with decimation over a shared coefficient table.
// ----------------------------------------------------------------------------
// Items enter on the slave stream and are classified by a front stage into a
// two-entry command queue; the filter engine behind it works on one command at
// a time. The engine writes a coefficient straight from the queue and loads a
// bypassed sample (ratio 1) into the output register once that register is
// free. A filtered sample runs through a start step that writes the delay
// line, one multiply-accumulate per tap through the single shared 16x18
// multiplier, then a drain while the read/multiply/accumulate pipeline
// empties and the result is loaded once the output register is free. The
// front keeps taking items while the queue has room, and the output register
// lets a finished result wait while the next item runs.
// Delay lines are tracked by per-channel fill counts, so reset and register
// writes take effect at once with no clearing pass.
// ----------------------------------------------------------------------------
module multichannel_fir_decimator #(
    parameter int CHANNELS = mcfd_pkg::CHANNELS_DEF,
    parameter int TAPS     = mcfd_pkg::TAPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // channel, sample, coef_index, coef_value (from bit 0 up)
    input  logic [mcfd_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // mode
    input  logic [mcfd_pkg::S_TUSER_W-1:0]    i_s_tuser,
    // master stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // out_channel, out_sample (from bit 0 up)
    output logic [mcfd_pkg::M_TDATA_W-1:0]    o_m_tdata,
    // register write port
    input  logic                              i_cfg_wr_en,
    input  logic [mcfd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mcfd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import mcfd_pkg::*;

    localparam int FW = $clog2(TAPS + 1);

    logic [RATIO_W-1:0]   r_ratio;
    logic [TAPSREG_W-1:0] r_taps;
    logic [RATIO_W-1:0]   w_ratio_eff;
    logic [FW-1:0]        w_taps_eff;
    logic                 w_push;
    logic                 w_pop;
    logic                 w_q_full;
    logic                 w_q_empty;
    t_cmd                 w_cmd_in;
    t_cmd                 w_cmd_out;
    t_back_stat           w_stat;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio <= RATIO_W'(1);
            r_taps  <= TAPSREG_W'(1);
        end else if (i_cfg_wr_en) begin
            case (t_reg'(i_cfg_index))
                REG_RATIO: r_ratio <= i_cfg_data[RATIO_W-1:0];
                REG_TAPS:  r_taps  <= i_cfg_data[TAPSREG_W-1:0];
                default:   r_ratio <= r_ratio;
            endcase
        end
    end

    // effective ratio and tap count
    always_comb begin
        if (r_ratio == '0) begin
            w_ratio_eff = RATIO_W'(1);
        end else if (r_ratio > RATIO_W'(RATIO_MAX)) begin
            w_ratio_eff = RATIO_W'(RATIO_MAX);
        end else begin
            w_ratio_eff = r_ratio;
        end
        if (r_taps == '0) begin
            w_taps_eff = FW'(1);
        end else if (32'(r_taps) > TAPS) begin
            w_taps_eff = FW'(TAPS);
        end else begin
            w_taps_eff = FW'(r_taps);
        end
    end

    mcfd_front #(
        .CHANNELS (CHANNELS),
        .TAPS     (TAPS)
    ) u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_ratio    (w_ratio_eff),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_cmd      (w_cmd_in)
    );

    mcfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cmd_in),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_data  (w_cmd_out),
        .o_empty (w_q_empty)
    );

    // any register write clears delay lines and phase counters
    mcfd_back #(
        .CHANNELS (CHANNELS),
        .TAPS     (TAPS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (i_cfg_wr_en),
        .i_taps     (w_taps_eff),
        .i_ratio    (w_ratio_eff),
        .i_q_empty  (w_q_empty),
        .i_cmd      (w_cmd_out),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_stat     (w_stat)
    );

    // no push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("command queue overflow");

    // the engine only pops a present command, and only when idle
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (!w_q_empty && w_stat.idle))
        else $error("pop without a command or while busy");

    // a waiting result is never overwritten
    a_no_clobber: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.out_load |-> (!o_m_tvalid || i_m_tready))
        else $error("output item overwritten before it was taken");

endmodule

@@ rtl/mcfd_ram.sv @@
// ----------------------------------------------------------------------------
// mcfd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mcfd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/mcfd_queue.sv @@
// ----------------------------------------------------------------------------
// mcfd_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module mcfd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mcfd_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output mcfd_pkg::t_cmd o_data,
    output logic           o_empty
);
    import mcfd_pkg::*;

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    t_cmd           r_mem [QUEUE_DEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QCW-1:0] r_count;
    logic [QAW-1:0] n_wp;
    logic [QAW-1:0] n_rp;

    assign o_full  = (r_count == QCW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rp];

    // pointer wrap
    always_comb begin
        n_wp = (r_wp == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QAW'(1);
        n_rp = (r_rp == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QAW'(1);
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= n_wp;
            end
            if (i_pop) begin
                r_rp <= n_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCW'(1);
                2'b01:   r_count <= r_count - QCW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/mcfd_front.sv @@
// ----------------------------------------------------------------------------
// mcfd_front
// Input handshake and classification of items into back-end commands.
// ----------------------------------------------------------------------------
module mcfd_front #(
    parameter int CHANNELS = mcfd_pkg::CHANNELS_DEF,
    parameter int TAPS     = mcfd_pkg::TAPS_DEF
) (
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [mcfd_pkg::S_TDATA_W-1:0]   i_s_tdata,
    input  logic [mcfd_pkg::S_TUSER_W-1:0]   i_s_tuser,
    input  logic [mcfd_pkg::RATIO_W-1:0]     i_ratio,
    input  logic                             i_q_full,
    output logic                             o_push,
    output mcfd_pkg::t_cmd                   o_cmd
);
    import mcfd_pkg::*;

    t_mode w_mode;
    logic  w_accept;
    logic  w_keep;

    assign o_s_tready = !i_q_full;
    assign w_accept   = i_s_tvalid && !i_q_full;
    assign w_mode     = t_mode'(i_s_tuser[0]);

    // unpack fields and pick the command kind
    always_comb begin
        o_cmd.ch     = i_s_tdata[TD_CH_LSB +: CH_W];
        o_cmd.sample = $signed(i_s_tdata[TD_SMP_LSB +: SAMPLE_W]);
        o_cmd.cidx   = i_s_tdata[TD_CIDX_LSB +: CIDX_W];
        o_cmd.cval   = $signed(i_s_tdata[TD_CVAL_LSB +: COEF_W]);
        case (w_mode)
            MODE_COEF: begin
                o_cmd.kind = CMD_COEF;
                w_keep     = (32'(o_cmd.cidx) < TAPS);
            end
            MODE_SAMPLE: begin
                o_cmd.kind = (i_ratio == RATIO_W'(1)) ? CMD_BYPASS : CMD_SAMPLE;
                w_keep     = (32'(o_cmd.ch) < CHANNELS);
            end
            default: begin
                o_cmd.kind = CMD_SAMPLE;
                w_keep     = 1'b0;
            end
        endcase
    end

    // items with an out-of-range channel or tap are dropped here
    assign o_push = w_accept && w_keep;

endmodule

@@ rtl/mcfd_back.sv @@
// ----------------------------------------------------------------------------
// mcfd_back
// Filter engine: coefficient writes, delay lines, one MAC per tap, output stage.
// ----------------------------------------------------------------------------
module mcfd_back #(
    parameter int CHANNELS = mcfd_pkg::CHANNELS_DEF,
    parameter int TAPS     = mcfd_pkg::TAPS_DEF,
    localparam int FW      = $clog2(TAPS + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_clear,
    input  logic [FW-1:0]                  i_taps,
    input  logic [mcfd_pkg::RATIO_W-1:0]   i_ratio,
    input  logic                           i_q_empty,
    input  mcfd_pkg::t_cmd                 i_cmd,
    output logic                           o_pop,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [mcfd_pkg::M_TDATA_W-1:0] o_m_tdata,
    output mcfd_pkg::t_back_stat           o_stat
);
    import mcfd_pkg::*;

    localparam int TW         = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CW         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CHX        = (CW > CH_W) ? CW : CH_W;
    localparam int COEF_DEPTH = (TAPS < COEF_MAX_DEPTH) ? TAPS : COEF_MAX_DEPTH;
    localparam int CAW        = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
    localparam int LINE_DEPTH = CHANNELS * (1 << TW);
    localparam int LAW        = CW + TW;
    localparam int QW         = ACC_W - ROUND_SHIFT;
    localparam logic signed [QW-1:0] Q_MAX = QW'(SMP_MAX);
    localparam logic signed [QW-1:0] Q_MIN = QW'(SMP_MIN);

    // control
    t_state                     r_state;
    t_state                     n_state;
    t_cmd                       r_cmd;
    logic [CW-1:0]              r_ch;
    logic                       r_emit;
    logic [FW-1:0]              r_k;
    logic [TW-1:0]              r_ptr;
    logic [FW-1:0]              r_fill_cur;

    // per-channel line state and coefficient valid bits
    logic [TW-1:0]              r_wp    [CHANNELS];
    logic [FW-1:0]              r_fill  [CHANNELS];
    logic [PHASE_W-1:0]         r_phase [CHANNELS];
    logic [COEF_DEPTH-1:0]      r_cvalid;

    // mac pipeline
    logic                       r_p1_v;
    logic                       r_p1_dvalid;
    logic                       r_p1_cexist;
    logic                       r_p1_cvalid;
    logic                       r_p1_k0;
    logic                       r_p2_v;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;

    // output register
    logic                       r_out_v;
    logic [CH_W-1:0]            r_out_ch;
    logic signed [SAMPLE_W-1:0] r_out_smp;

    // combinational
    logic [CHX-1:0]             w_ch_x;
    logic [CW-1:0]              w_ch;
    logic [TW-1:0]              w_np;
    logic [FW-1:0]              w_fill_new;
    logic [PHASE_W:0]           w_next_phase;
    logic                       w_emit;
    logic                       w_out_free;
    logic                       w_last_tap;
    logic                       w_pipe_empty;
    logic                       w_start;
    logic                       w_coef_we;
    logic                       w_line_we;
    logic                       w_load_bypass;
    logic                       w_load_filt;
    logic [SAMPLE_W-1:0]        w_line_rd;
    logic [COEF_W-1:0]          w_coef_rd;
    logic signed [SAMPLE_W-1:0] w_d;
    logic signed [COEF_W-1:0]   w_c;
    logic signed [ACC_W-1:0]    w_rnd;
    logic signed [QW-1:0]       w_q;
    logic signed [SAMPLE_W-1:0] w_sat;

    // head-of-queue channel and the line update it causes
    always_comb begin
        w_ch_x       = CHX'(i_cmd.ch);
        w_ch         = w_ch_x[CW-1:0];
        w_np         = (r_wp[w_ch] == TW'(TAPS - 1)) ? '0 : r_wp[w_ch] + TW'(1);
        w_fill_new   = (r_fill[w_ch] == FW'(TAPS)) ? r_fill[w_ch]
                                                   : r_fill[w_ch] + FW'(1);
        w_next_phase = {1'b0, r_phase[w_ch]} + (PHASE_W+1)'(1);
        w_emit       = (w_next_phase >= i_ratio);
    end

    assign w_out_free   = !r_out_v || i_m_tready;
    assign w_last_tap   = (r_k == i_taps - FW'(1));
    assign w_pipe_empty = !r_p1_v && !r_p2_v;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty && (i_cmd.kind == CMD_SAMPLE)) begin
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                if (w_last_tap) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (w_pipe_empty && (!r_emit || w_out_free)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_pop         = 1'b0;
        w_start       = 1'b0;
        w_coef_we     = 1'b0;
        w_line_we     = 1'b0;
        w_load_bypass = 1'b0;
        w_load_filt   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    case (i_cmd.kind)
                        CMD_COEF: begin
                            o_pop     = 1'b1;
                            w_coef_we = 1'b1;
                        end
                        CMD_BYPASS: begin
                            o_pop         = w_out_free;
                            w_load_bypass = w_out_free;
                        end
                        CMD_SAMPLE: begin
                            o_pop     = 1'b1;
                            w_start   = 1'b1;
                            w_line_we = 1'b1;
                        end
                        default: o_pop = 1'b1;
                    endcase
                end
            end
            S_DRAIN: begin
                w_load_filt = w_pipe_empty && r_emit && w_out_free;
            end
            default: o_pop = 1'b0;
        endcase
    end

    assign o_stat.pop      = o_pop;
    assign o_stat.out_load = w_load_bypass || w_load_filt;
    assign o_stat.idle     = (r_state == S_IDLE);

    // delay lines, one row per channel, newest at the write pointer
    mcfd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (w_line_we),
        .i_waddr (LAW'({w_ch, w_np})),
        .i_wdata (i_cmd.sample),
        .i_raddr (LAW'({r_ch, r_ptr})),
        .o_rdata (w_line_rd)
    );

    // shared coefficient table
    mcfd_ram #(
        .WIDTH (COEF_W),
        .DEPTH (COEF_DEPTH)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_coef_we),
        .i_waddr (i_cmd.cidx[CAW-1:0]),
        .i_wdata (i_cmd.cval),
        .i_raddr (r_k[CAW-1:0]),
        .o_rdata (w_coef_rd)
    );

    // masking of unfilled line slots and unwritten coefficients
    always_comb begin
        w_d = r_p1_dvalid ? $signed(w_line_rd) : '0;
        if (!r_p1_cexist) begin
            w_c = '0;
        end else if (r_p1_cvalid) begin
            w_c = $signed(w_coef_rd);
        end else begin
            w_c = r_p1_k0 ? COEF_ONE : '0;
        end
    end

    // round half up, then saturate to the sample range
    always_comb begin
        w_rnd = r_acc + ACC_W'(ROUND_HALF);
        w_q   = w_rnd[ACC_W-1:ROUND_SHIFT];
        if (w_q > Q_MAX) begin
            w_sat = SAMPLE_W'(SMP_MAX);
        end else if (w_q < Q_MIN) begin
            w_sat = SAMPLE_W'(SMP_MIN);
        end else begin
            w_sat = w_q[SAMPLE_W-1:0];
        end
    end

    // control registers and per-channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_p1_v   <= 1'b0;
            r_p2_v   <= 1'b0;
            r_out_v  <= 1'b0;
            r_cvalid <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_wp[i]    <= '0;
                r_fill[i]  <= '0;
                r_phase[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_p1_v  <= (r_state == S_MAC);
            r_p2_v  <= r_p1_v;
            if (w_load_bypass || w_load_filt) begin
                r_out_v <= 1'b1;
            end else if (i_m_tready) begin
                r_out_v <= 1'b0;
            end
            if (w_coef_we) begin
                r_cvalid[i_cmd.cidx[CAW-1:0]] <= 1'b1;
            end
            if (i_clear) begin
                for (int i = 0; i < CHANNELS; i++) begin
                    r_wp[i]    <= '0;
                    r_fill[i]  <= '0;
                    r_phase[i] <= '0;
                end
            end else if (w_start) begin
                r_wp[w_ch]    <= w_np;
                r_fill[w_ch]  <= w_fill_new;
                r_phase[w_ch] <= w_emit ? '0 : w_next_phase[PHASE_W-1:0];
            end
        end
    end

    // item context and tap walk
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_cmd      <= i_cmd;
            r_ch       <= w_ch;
            r_emit     <= w_emit;
            r_k        <= '0;
            r_ptr      <= w_np;
            r_fill_cur <= w_fill_new;
        end else if (r_state == S_MAC) begin
            r_k   <= r_k + FW'(1);
            r_ptr <= (r_ptr == '0) ? TW'(TAPS - 1) : r_ptr - TW'(1);
        end
    end

    // mac datapath: read, multiply, accumulate
    always_ff @(posedge i_clk) begin
        r_p1_dvalid <= (r_k < r_fill_cur);
        r_p1_cexist <= (32'(r_k) < COEF_DEPTH);
        r_p1_cvalid <= r_cvalid[r_k[CAW-1:0]];
        r_p1_k0     <= (r_k == '0);
        r_prod      <= w_d * w_c;
        if (w_start) begin
            r_acc <= '0;
        end else if (r_p2_v) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_load_bypass) begin
            r_out_ch  <= i_cmd.ch;
            r_out_smp <= i_cmd.sample;
        end else if (w_load_filt) begin
            r_out_ch  <= r_cmd.ch;
            r_out_smp <= w_sat;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {{(M_TDATA_W - CH_W - SAMPLE_W){1'b0}}, r_out_smp, r_out_ch};

endmodule

@@ verif/fir_decim_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fir_decim_checker
// Watches the item streams and register port of the multichannel FIR
// decimator, keeps its own copy of the filter state, works out every output
// item in advance and compares what the block sends, field by field.
// ----------------------------------------------------------------------------
module fir_decim_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic                              i_s_tready,
    // channel, sample, coef_index, coef_value (from bit 0 up)
    input  logic [mcfd_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // mode
    input  logic [mcfd_pkg::S_TUSER_W-1:0]    i_s_tuser,
    input  logic                              i_m_tvalid,
    input  logic                              i_m_tready,
    // out_channel, out_sample (from bit 0 up)
    input  logic [mcfd_pkg::M_TDATA_W-1:0]    i_m_tdata,
    input  logic                              i_cfg_wr_en,
    input  logic [mcfd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mcfd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending
);
    import mcfd_pkg::*;

    localparam int NUM_CH      = CHANNELS_DEF;
    localparam int NUM_TAPS    = TAPS_DEF;
    localparam int MAX_REPORTS = 20;

    typedef struct packed {
        logic [CH_W-1:0]            ch;
        logic signed [SAMPLE_W-1:0] smp;
    } t_audio_out;

    // filter state as the block should hold it
    logic [RATIO_W-1:0]          ratio_reg;
    logic [TAPSREG_W-1:0]        taps_reg;
    logic signed [SAMPLE_W-1:0]  history [NUM_CH][NUM_TAPS];
    logic [PHASE_W-1:0]          phase [NUM_CH];
    logic signed [COEF_W-1:0]    coefs [NUM_TAPS];

    // outputs still owed by the block, oldest first
    t_audio_out                  expected_q [$];

    task automatic report_mismatch(input string msg);
        if (o_fail_count < MAX_REPORTS) begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
        o_fail_count++;
    endtask

    // append one owed output at the tail
    task automatic owe_result(input t_audio_out res);
        expected_q.insert(expected_q.size(), res);
    endtask

    task automatic clear_history();
        for (int c = 0; c < NUM_CH; c++) begin
            phase[c] = '0;
            for (int k = 0; k < NUM_TAPS; k++) begin
                history[c][k] = '0;
            end
        end
    endtask

    task automatic reset_model();
        ratio_reg = RATIO_W'(1);
        taps_reg  = TAPSREG_W'(1);
        clear_history();
        for (int k = 0; k < NUM_TAPS; k++) begin
            coefs[k] = '0;
        end
        coefs[0] = COEF_ONE;
        expected_q.delete();
    endtask

    // any write to a known register restarts all channels
    task automatic write_register(input t_reg idx, input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_RATIO: begin
                ratio_reg = val[RATIO_W-1:0];
                clear_history();
            end
            REG_TAPS: begin
                taps_reg = val[TAPSREG_W-1:0];
                clear_history();
            end
            default: ;
        endcase
    endtask

    task automatic filter_item(input t_mode mode, input logic [CH_W-1:0] ch,
                               input logic signed [SAMPLE_W-1:0] x,
                               input logic [CIDX_W-1:0] cidx,
                               input logic signed [COEF_W-1:0] cval);
        int unsigned ratio_eff;
        int unsigned taps_eff;
        int unsigned next_phase;
        longint      acc;
        t_audio_out  res;

        // coefficient table write, no output
        if (mode == MODE_COEF) begin
            if (cidx < NUM_TAPS) begin
                coefs[cidx] = cval;
            end
            return;
        end
        if (ch >= NUM_CH) begin
            return;
        end

        ratio_eff = (ratio_reg == 0) ? 1 : ratio_reg;
        if (ratio_eff > RATIO_MAX) begin
            ratio_eff = RATIO_MAX;
        end
        res.ch = ch;

        // bypass: raw sample out, delay line and phase untouched
        if (ratio_eff == 1) begin
            res.smp = x;
            owe_result(res);
            return;
        end

        taps_eff = (taps_reg == 0) ? 1 : taps_reg;
        if (taps_eff > NUM_TAPS) begin
            taps_eff = NUM_TAPS;
        end

        // newest sample goes to position 0
        for (int k = NUM_TAPS - 1; k > 0; k--) begin
            history[ch][k] = history[ch][k-1];
        end
        history[ch][0] = x;

        acc = 0;
        for (int k = 0; k < taps_eff; k++) begin
            acc += longint'(history[ch][k]) * longint'(coefs[k]);
        end

        // round half up from Q2.32 to Q1.15, then clamp to 16 bits
        acc = (acc + 65536) >>> ROUND_SHIFT;
        if (acc > SMP_MAX) begin
            acc = SMP_MAX;
        end else if (acc < SMP_MIN) begin
            acc = SMP_MIN;
        end

        next_phase = phase[ch] + 1;
        if (next_phase >= ratio_eff) begin
            phase[ch] = '0;
            res.smp = SAMPLE_W'(acc);
            owe_result(res);
        end else begin
            phase[ch] = PHASE_W'(next_phase);
        end
    endtask

    task automatic check_output(input logic [M_TDATA_W-1:0] data);
        t_audio_out got;
        t_audio_out want;

        got.ch  = data[0 +: CH_W];
        got.smp = data[CH_W +: SAMPLE_W];
        if (expected_q.size() == 0) begin
            report_mismatch($sformatf("output item ch %0d value %0d with nothing expected",
                                      got.ch, got.smp));
            return;
        end
        want = expected_q.pop_front();
        if (got.ch != want.ch) begin
            report_mismatch($sformatf("channel %0d, expected %0d", got.ch, want.ch));
        end
        if (got.smp != want.smp) begin
            report_mismatch($sformatf("ch %0d value %0d, expected %0d",
                                      want.ch, got.smp, want.smp));
        end
    endtask

    // everything is sampled at the rising edge, before the drivers move
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                check_output(i_m_tdata);
            end
            if (i_cfg_wr_en) begin
                write_register(t_reg'(i_cfg_index), i_cfg_data);
            end
            if (i_s_tvalid && i_s_tready) begin
                filter_item(t_mode'(i_s_tuser[0]),
                            i_s_tdata[TD_CH_LSB +: CH_W],
                            i_s_tdata[TD_SMP_LSB +: SAMPLE_W],
                            i_s_tdata[TD_CIDX_LSB +: CIDX_W],
                            i_s_tdata[TD_CVAL_LSB +: COEF_W]);
            end
        end
        o_pending = expected_q.size();
    end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the multichannel FIR decimator with directed and random audio and
// coefficient items over a range of ratio and tap settings, with bursty input,
// a stalling output and one long output hold-off; the checker beside the
// block predicts and compares every output item.
// ----------------------------------------------------------------------------
module testbench;

    import mcfd_pkg::*;

    localparam int CLK_HALF_NS    = 5;
    localparam int RESET_CYCLES   = 7;
    localparam int RANDOM_ITEMS   = 550;
    localparam int DRAIN_CYCLES   = 450;
    localparam int RX_HOLD_CYCLES = 1500;
    localparam int TIMEOUT_NS     = 8_000_000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int                    fail_count;
    int                    pending;
    int                    burst_left = 0;

    // output hold-off request and receiver bookkeeping
    bit                    rx_hold_req  = 1'b0;
    bit                    rx_hold_done = 1'b0;
    int                    rx_hold_left = 0;
    logic [31:0]           rx_tick      = '0;

    always begin
        #CLK_HALF_NS clk = 1'b1;
        #CLK_HALF_NS clk = 1'b0;
    end

    multichannel_fir_decimator i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    fir_decim_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // receiver: one long hold-off on request, otherwise a pattern per window
    always @(posedge clk) begin
        rx_tick = rx_tick + 1;
        if (rx_hold_req && !rx_hold_done) begin
            if (rx_hold_left == 0) begin
                rx_hold_left = RX_HOLD_CYCLES;
            end
            rx_hold_left--;
            if (rx_hold_left == 0) begin
                rx_hold_done = 1'b1;
            end
            m_tready <= 1'b0;
        end else begin
            case (rx_tick[9:8])
                2'd0:    m_tready <= 1'b1;
                2'd1:    m_tready <= ($urandom_range(0, 1) == 1);
                2'd2:    m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (rx_tick % 3 == 0);
            endcase
        end
    end

    // a fifth of values at the rails or around zero
    function automatic int rand_sample();
        case ($urandom_range(0, 19))
            0:       return SMP_MAX;
            1:       return SMP_MIN;
            2:       return 0;
            3:       return -1;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // offer one item in bursts with random gaps, return once it is taken
    task automatic send_item(input t_mode mode, input int ch, input int smp,
                             input int cidx, input int cval);
        int gap_len;

        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap_len > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap_len) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= S_TDATA_W'({COEF_W'(cval), CIDX_W'(cidx), SAMPLE_W'(smp), CH_W'(ch)});
        do @(negedge clk); while (!s_tready);
        @(posedge clk);
    endtask

    // stop offering, let owed outputs arrive and silent items finish
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(negedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input bit do_ratio, input int ratio_val,
                              input bit do_taps, input int taps_val);
        wait_idle();
        if (do_ratio) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= REG_RATIO;
            cfg_data  <= CFG_DATA_W'(ratio_val);
            @(posedge clk);
        end
        if (do_taps) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= REG_TAPS;
            cfg_data  <= CFG_DATA_W'(taps_val);
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        #TIMEOUT_NS;
        $display("testbench NOT OK");
        $finish;
    end

    initial begin
        int  n_random;
        int  phase_no;
        int  n_items;
        int  ratio_val;
        int  taps_val;
        int  taps_eff;
        int  n_load;
        int  lim;
        bit  do_ratio;
        bit  do_taps;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings bypass: rails, zero, minus one, alternating bits
        send_item(MODE_SAMPLE, 0, SMP_MAX, 0, 0);
        send_item(MODE_SAMPLE, 7, SMP_MIN, 127, 0);
        send_item(MODE_SAMPLE, 3, 0, 0, 0);
        send_item(MODE_SAMPLE, 5, -1, 127, -1);
        send_item(MODE_SAMPLE, 2, 'h5555, 0, 0);
        send_item(MODE_SAMPLE, 1, -21846, 0, 0);

        // coefficient writes at index 127 and index 1, at both ends of the value range
        send_item(MODE_COEF, 7, -1, 127, 131071);
        send_item(MODE_COEF, 0, 0, 1, -131072);

        // ratio zero behaves as bypass
        write_regs(1'b1, 0, 1'b0, 0);
        send_item(MODE_SAMPLE, 4, 12345, 0, 0);

        // ratio two, taps zero acts as a single tap
        write_regs(1'b1, 2, 1'b1, 0);
        send_item(MODE_SAMPLE, 6, SMP_MAX, 0, 0);
        send_item(MODE_SAMPLE, 6, SMP_MIN, 0, 0);

        // taps of opposite sign push the output into both rails
        write_regs(1'b0, 0, 1'b1, 2);
        send_item(MODE_SAMPLE, 0, SMP_MIN, 0, 0);
        send_item(MODE_SAMPLE, 0, SMP_MAX, 0, 0);
        send_item(MODE_SAMPLE, 0, SMP_MAX, 0, 0);
        send_item(MODE_SAMPLE, 0, SMP_MIN, 0, 0);

        // taps register beyond the table size clamps to the full table
        write_regs(1'b1, 3, 1'b1, 511);
        send_item(MODE_SAMPLE, 2, 1000, 0, 0);
        send_item(MODE_SAMPLE, 2, -1000, 0, 0);
        send_item(MODE_SAMPLE, 2, 20000, 0, 0);

        // random phases, each with its own settings
        n_random = 0;
        phase_no = 0;
        while (n_random < RANDOM_ITEMS) begin
            if (phase_no == 3) begin
                // ratio above the limit clamps to 256, full table, one channel
                write_regs(1'b1, 300, 1'b1, 128);
                for (int i = 0; i < RATIO_MAX; i++) begin
                    send_item(MODE_SAMPLE, 5, rand_sample(), $urandom_range(0, 127),
                              int'($urandom_range(0, 262143)) - 131072);
                end
                n_random += RATIO_MAX;
            end else begin
                case ($urandom_range(0, 9))
                    0:                   ratio_val = $urandom_range(0, 1);
                    1, 2, 3, 4, 5, 6, 7: ratio_val = $urandom_range(2, 8);
                    8:                   ratio_val = $urandom_range(9, 32);
                    default:             ratio_val = 1;
                endcase
                // the hold-off phase runs in bypass so outputs pile up fast
                if (phase_no == 1) begin
                    ratio_val = 1;
                end
                case ($urandom_range(0, 7))
                    0:       taps_val = $urandom_range(17, 128);
                    1:       taps_val = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(129, 511);
                    default: taps_val = $urandom_range(1, 16);
                endcase
                do_ratio = (phase_no == 1) || ($urandom_range(0, 4) != 0);
                do_taps  = !do_ratio || ($urandom_range(0, 4) != 0);
                write_regs(do_ratio, ratio_val, do_taps, taps_val);

                taps_eff = taps_val & 255;
                if (taps_eff == 0) begin
                    taps_eff = 1;
                end else if (taps_eff > TAPS_DEF) begin
                    taps_eff = TAPS_DEF;
                end
                lim = (131071 >> $urandom_range(0, 6)) / taps_eff;
                if (lim < 1) begin
                    lim = 1;
                end

                // load the leading taps with values scaled to the tap count
                n_load = (taps_eff < 12) ? taps_eff : 12;
                for (int k = 0; k < n_load; k++) begin
                    send_item(MODE_COEF, $urandom_range(0, 7), rand_sample(), k,
                              int'($urandom_range(0, 2 * lim)) - lim);
                end

                if (phase_no == 1) begin
                    rx_hold_req = 1'b1;
                end

                // mostly audio, with the odd coefficient update in between
                n_items = $urandom_range(20, 50);
                for (int i = 0; i < n_items; i++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send_item(MODE_COEF, $urandom_range(0, 7), rand_sample(),
                                  $urandom_range(0, 127),
                                  int'($urandom_range(0, 2 * lim)) - lim);
                    end else begin
                        send_item(MODE_SAMPLE, $urandom_range(0, 7), rand_sample(),
                                  $urandom_range(0, 127),
                                  int'($urandom_range(0, 262143)) - 131072);
                    end
                end
                n_random += n_load + n_items;
            end
            phase_no++;
        end

        wait_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
